>>> rtl/lphs_pkg.sv
// Shared constants and types for the linear-probing hash set.
`default_nettype none
package lphs_pkg;

	localparam int TABLE_SIZE_DEF = 16;
	localparam int KEY_WIDTH_DEF  = 16;
	localparam int KEY_IN_W       = 16;
	localparam int STATUS_W       = 3;
	localparam int SLOT_W         = 4;
	localparam int FRAC_W         = 32;
	localparam int QUEUE_DEPTH    = 2;

	// round(2^32 * (sqrt(5) - 1) / 2), unsigned 0.32
	localparam logic [FRAC_W-1:0] GOLDEN_FIX = 32'd2654435769;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_ZERO_KEY  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PROBE,
		BK_DONE
	} back_state_t;

endpackage
`default_nettype wire

>>> rtl/lphs_req_if.sv
// Request channel: insert or search of one key.
`default_nettype none
interface lphs_req_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [lphs_pkg::KEY_IN_W-1:0] key;

	modport source(output valid, req_type, key, input ready);
	modport sink(input valid, req_type, key, output ready);
endinterface
`default_nettype wire

>>> rtl/lphs_rsp_if.sv
// Response channel: status and slot of one request.
`default_nettype none
interface lphs_rsp_if;
	logic                        valid;
	logic                        ready;
	lphs_pkg::status_t           status;
	logic [lphs_pkg::SLOT_W-1:0] slot_index;

	modport source(output valid, status, slot_index, input ready);
	modport sink(input valid, status, slot_index, output ready);
endinterface
`default_nettype wire

>>> rtl/lphs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lphs_ram #(
	parameter int WIDTH = lphs_pkg::KEY_WIDTH_DEF,
	parameter int DEPTH = lphs_pkg::TABLE_SIZE_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> rtl/lphs_front.sv
// Front end: accepts requests, masks the key, computes the home slot.
`default_nettype none
module lphs_front #(
	parameter int TABLE_SIZE = lphs_pkg::TABLE_SIZE_DEF,
	parameter int KEY_WIDTH  = lphs_pkg::KEY_WIDTH_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	lphs_req_if.sink                                        req,
	output logic                                            push_valid,
	input  wire logic                                       push_ready,
	output logic [2+KEY_WIDTH+$clog2(TABLE_SIZE)-1:0]       push_data
);

	localparam int AW         = $clog2(TABLE_SIZE);
	localparam int KeyInW     = lphs_pkg::KEY_IN_W;
	localparam int FracW      = lphs_pkg::FRAC_W;
	localparam int ProdW      = FracW + AW + 1;
	localparam int KeyInUsed  = (KEY_WIDTH < KeyInW) ? KEY_WIDTH : KeyInW;
	localparam logic [KeyInW:0] KeyMaskW =
		((KeyInW+1)'(1) << KeyInUsed) - (KeyInW+1)'(1);
	localparam logic [KeyInW-1:0] KeyMask = KeyMaskW[KeyInW-1:0];

	logic              valid_s1, valid_s2;
	logic              search_s1, search_s2;
	logic [KeyInW-1:0] key_s1, key_s2;
	logic              zero_s2;
	logic [FracW-1:0]  frac_s2;
	logic              rdy1, rdy2;
	logic [ProdW-1:0]  prod;
	logic [AW-1:0]     home;

	assign rdy2      = !valid_s2 || push_ready;
	assign rdy1      = !valid_s1 || rdy2;
	assign req.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= req.valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			search_s1 <= req.req_type;
			key_s1    <= req.key & KeyMask;
		end
		if (rdy2) begin
			search_s2 <= search_s1;
			key_s2    <= key_s1;
			zero_s2   <= (key_s1 == '0);
			frac_s2   <= FracW'(FracW'(key_s1) * lphs_pkg::GOLDEN_FIX);
		end
	end

	assign prod       = ProdW'(frac_s2) * ProdW'(TABLE_SIZE);
	assign home       = prod[FracW +: AW];
	assign push_valid = valid_s2;
	assign push_data  = {search_s2, zero_s2, KEY_WIDTH'(key_s2), home};

endmodule
`default_nettype wire

>>> rtl/lphs_fifo.sv
// Short queue between the front end and the probe engine.
`default_nettype none
module lphs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = lphs_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic      [WIDTH-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

>>> rtl/lphs_back.sv
// Probe engine: walks the slots one per cycle, inserts or matches, drives the result.
`default_nettype none
module lphs_back #(
	parameter int TABLE_SIZE = lphs_pkg::TABLE_SIZE_DEF,
	parameter int KEY_WIDTH  = lphs_pkg::KEY_WIDTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   q_valid,
	output logic                                        q_ready,
	input  wire logic [2+KEY_WIDTH+$clog2(TABLE_SIZE)-1:0] q_data,
	lphs_rsp_if.source                                  rsp
);

	localparam int AW    = $clog2(TABLE_SIZE);
	localparam int SlotW = lphs_pkg::SLOT_W;

	lphs_pkg::back_state_t state_q, state_d;

	logic                  search_in, zero_in;
	logic [KEY_WIDTH-1:0]  key_in;
	logic [AW-1:0]         home_in;

	logic                  search_q;
	logic [KEY_WIDTH-1:0]  key_q;
	logic [AW-1:0]         probe_addr_q, cmp_addr_q, probe_next;
	logic [AW-1:0]         cmp_cnt_q;
	logic                  rd_vld_q, vrd_q;
	logic [TABLE_SIZE-1:0] valid_q;
	lphs_pkg::status_t     res_status_q, out_status_q;
	logic [SlotW-1:0]      res_slot_q, out_slot_q;
	logic                  out_valid_q;
	logic [KEY_WIDTH-1:0]  rdata;

	logic pop, probing, hit, we, out_load;

	assign {search_in, zero_in, key_in, home_in} = q_data;
	assign probe_next = (probe_addr_q == AW'(TABLE_SIZE - 1)) ? '0 : probe_addr_q + AW'(1);
	assign hit = rd_vld_q && (search_q ? (vrd_q && (rdata == key_q)) : !vrd_q);
	assign we  = probing && hit && !search_q;

	lphs_ram #(
		.WIDTH(KEY_WIDTH),
		.DEPTH(TABLE_SIZE)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(cmp_addr_q),
		.wdata(key_q),
		.raddr(probe_addr_q),
		.rdata(rdata)
	);

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		probing  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			lphs_pkg::BK_IDLE: begin
				if (q_valid) begin
					pop     = 1'b1;
					state_d = zero_in ? lphs_pkg::BK_DONE : lphs_pkg::BK_PROBE;
				end
			end
			lphs_pkg::BK_PROBE: begin
				probing = 1'b1;
				if (hit || (rd_vld_q && (cmp_cnt_q == AW'(TABLE_SIZE - 1)))) begin
					state_d = lphs_pkg::BK_DONE;
				end
			end
			lphs_pkg::BK_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = lphs_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = lphs_pkg::BK_IDLE;
			end
		endcase
	end

	assign q_ready = pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lphs_pkg::BK_IDLE;
			valid_q     <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				rd_vld_q <= 1'b0;
			end else if (probing) begin
				rd_vld_q <= 1'b1;
			end
			if (we) begin
				valid_q[cmp_addr_q] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			search_q     <= search_in;
			key_q        <= key_in;
			probe_addr_q <= home_in;
			cmp_cnt_q    <= '0;
			res_slot_q   <= '0;
			if (zero_in) begin
				res_status_q <= lphs_pkg::ST_ZERO_KEY;
			end else if (search_in) begin
				res_status_q <= lphs_pkg::ST_NOT_FOUND;
			end else begin
				res_status_q <= lphs_pkg::ST_FULL;
			end
		end else if (probing) begin
			probe_addr_q <= probe_next;
			cmp_addr_q   <= probe_addr_q;
			vrd_q        <= valid_q[probe_addr_q];
			if (rd_vld_q) begin
				cmp_cnt_q <= cmp_cnt_q + AW'(1);
			end
			if (hit) begin
				res_status_q <= search_q ? lphs_pkg::ST_FOUND : lphs_pkg::ST_INSERTED;
				res_slot_q   <= SlotW'(cmp_addr_q);
			end
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.slot_index = out_slot_q;

endmodule
`default_nettype wire

>>> rtl/linear_probe_hash_set_core.sv
// Top level of the linear-probing hash set: front end, request queue, probe engine.
`default_nettype none
// Each request inserts or searches one nonzero key in a TABLE_SIZE-slot table with
// linear probing from a Knuth multiplicative-hash home slot. A zero key returns
// "zero key rejected"; an insert into a full table returns "table full" and a search
// miss returns "not found", both after probing every slot. The front end hashes in two
// pipeline stages and feeds a two-entry queue, so requests are taken while the probe
// engine is busy. The probe engine reads one slot per cycle from a RAM with separate
// read and write ports and registered read. Slot occupancy is held in per-slot flags
// cleared by reset, so the table is usable right after reset.
module linear_probe_hash_set_core #(
	parameter int TABLE_SIZE = lphs_pkg::TABLE_SIZE_DEF,
	parameter int KEY_WIDTH  = lphs_pkg::KEY_WIDTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lphs_req_if.sink   req,
	lphs_rsp_if.source rsp
);

	localparam int EntryW = 2 + KEY_WIDTH + $clog2(TABLE_SIZE);

	logic              push_valid, push_ready;
	logic [EntryW-1:0] push_data;
	logic              pop_valid, pop_ready;
	logic [EntryW-1:0] pop_data;

	lphs_front #(
		.TABLE_SIZE(TABLE_SIZE),
		.KEY_WIDTH (KEY_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	lphs_fifo #(
		.WIDTH(EntryW),
		.DEPTH(lphs_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	lphs_back #(
		.TABLE_SIZE(TABLE_SIZE),
		.KEY_WIDTH (KEY_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(pop_valid),
		.q_ready(pop_ready),
		.q_data (pop_data),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire
